/* sv/wcm_pkg.sv */
// ----------------------------------------------------------------------------
// wcm_pkg: shared definitions for the wildcard topic match unit
// Widths, register indexes, the star code and the link between match cells.
// ----------------------------------------------------------------------------
package wcm_pkg;

   localparam int MAX_PATTERN_CHARS_DEFAULT = 16;

   localparam int CHAR_W     = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int LEN_W      = 5;
   localparam int PATTERN_W  = 2 * CSR_DATA_W;

   localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   // carries from one pattern position to the next
   typedef struct packed {
      logic close0;   // star closure before the character
      logic adv;      // position reached by consuming the character
      logic close1;   // star closure after the character
   } link_type;

endpackage

/* sv/wcm_channels.sv */
// ----------------------------------------------------------------------------
// wcm channels: valid/ready interfaces for subject characters and results
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface wcm_req_if;
   logic                        valid;
   logic                        ready;
   logic [wcm_pkg::CHAR_W-1:0]  subject_char;
   logic                        last_char;
   logic                        empty_subject;

   modport source (output valid, output subject_char, output last_char,
                   output empty_subject, input ready);
   modport sink   (input valid, input subject_char, input last_char,
                   input empty_subject, output ready);
endinterface

interface wcm_rsp_if;
   logic valid;
   logic ready;
   logic is_match;

   modport source (output valid, output is_match, input ready);
   modport sink   (input valid, input is_match, output ready);
endinterface

/* sv/wildcard_topic_match_unit.sv */
// ----------------------------------------------------------------------------
// wildcard_topic_match_unit: streamed subject against a star-only pattern
// One subject character per transfer; one match flag per subject end.
// ----------------------------------------------------------------------------
// result: the result of a subject is registered and valid in the cycle after its final transfer
// throughput: one character per cycle while the input is not stalled, set by the
//   combinational ripple of the active bits through the chain of position cells
// a result waiting in the output register stalls the input until it is taken;
//   when the result side is ready it is taken and replaced in the same cycle
// reset: synchronous, active high; pattern registers clear to zero and only
//   the start position is active
module wildcard_topic_match_unit #(
   parameter int MAX_PATTERN_CHARS = wcm_pkg::MAX_PATTERN_CHARS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   wcm_req_if.sink                         req_chan,
   wcm_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [wcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wcm_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import wcm_pkg::*;

   localparam int POS_W = $clog2(MAX_PATTERN_CHARS + 1);
   localparam logic [MAX_PATTERN_CHARS:0] START_VEC = (MAX_PATTERN_CHARS + 1)'(1);

   // pattern registers
   logic [CSR_DATA_W-1:0] pat_low_ff, pat_high_ff;
   logic [LEN_W-1:0]      pat_len_ff;
   logic [PATTERN_W-1:0]  pattern;
   logic [POS_W-1:0]      len_used;

   // chain signals, one entry per pattern position plus the end position
   link_type                 link [MAX_PATTERN_CHARS+1];
   logic [MAX_PATTERN_CHARS:0] pos_en, pos_keep;
   logic [MAX_PATTERN_CHARS:0] act_vec, c0_vec, c1_vec;
   logic                       act_end_ff, act_end_in;

   // handshake and output register
   logic accept, subject_end;
   logic rsp_valid_ff, rsp_valid_in;
   logic is_match_ff, is_match_in;

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wr_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wr_data;
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_wr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern = {pat_high_ff, pat_low_ff};

   // a length above the cell count is taken as the cell count
   assign len_used = (pat_len_ff > LEN_W'(MAX_PATTERN_CHARS))
                   ? POS_W'(MAX_PATTERN_CHARS) : pat_len_ff[POS_W-1:0];

   // ------------------------------------------------------------------
   // transfer control: a waiting result only stalls if it is not taken
   // ------------------------------------------------------------------
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign subject_end    = req_chan.empty_subject || req_chan.last_char;

   // ------------------------------------------------------------------
   // chain of position cells
   // ------------------------------------------------------------------
   assign link[0] = '0;

   for (genvar i = 0; i <= MAX_PATTERN_CHARS; i++) begin : g_pos
      // positions below the length take part, the length position is kept
      assign pos_en[i]   = (POS_W'(i) < len_used);
      assign pos_keep[i] = (POS_W'(i) <= len_used);
   end

   for (genvar i = 0; i < MAX_PATTERN_CHARS; i++) begin : g_cell
      wcm_cell #(
         .START_BIT (START_VEC[i])
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .pat_char    (pattern[CHAR_W*i +: CHAR_W]),
         .sub_char    (req_chan.subject_char),
         .enable      (pos_en[i]),
         .keep        (pos_keep[i]),
         .accept      (accept),
         .subject_end (subject_end),
         .link_in     (link[i]),
         .link_out    (link[i+1]),
         .act         (act_vec[i]),
         .c0          (c0_vec[i]),
         .c1          (c1_vec[i])
      );
   end

   // end position: full pattern consumed, no character of its own
   assign act_vec[MAX_PATTERN_CHARS] = act_end_ff;
   assign c0_vec[MAX_PATTERN_CHARS]  = (act_end_ff & pos_keep[MAX_PATTERN_CHARS])
                                     | link[MAX_PATTERN_CHARS].close0;
   assign c1_vec[MAX_PATTERN_CHARS]  = link[MAX_PATTERN_CHARS].adv
                                     | link[MAX_PATTERN_CHARS].close1;

   always_comb begin
      act_end_in = act_end_ff;
      if (accept) begin
         act_end_in = subject_end ? START_VEC[MAX_PATTERN_CHARS]
                                  : c1_vec[MAX_PATTERN_CHARS];
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      is_match_in  = is_match_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && subject_end) begin
         rsp_valid_in = 1'b1;
         // an empty item adds no character: read the closed set before it
         is_match_in  = req_chan.empty_subject ? c0_vec[len_used] : c1_vec[len_used];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_end_ff   <= START_VEC[MAX_PATTERN_CHARS];
         rsp_valid_ff <= 1'b0;
      end else begin
         act_end_ff   <= act_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_match_ff <= is_match_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.is_match = is_match_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // every subject end rearms the chain at the start position
   a_end_rearms: assert property (@(posedge clock) disable iff (reset)
      accept && subject_end |=> act_vec == START_VEC)
      else $error("chain not rearmed after subject end");

   // a character inside the subject never creates or drops a result
   a_mid_no_result: assert property (@(posedge clock) disable iff (reset)
      accept && !subject_end |=> rsp_valid_ff == $past(rsp_valid_ff && !rsp_chan.ready))
      else $error("result changed by a mid-subject character");

   // a subject end always presents a result in the next cycle
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      accept && subject_end |=> rsp_valid_ff)
      else $error("subject end without result");

endmodule

/* sv/wcm_cell.sv */
// ----------------------------------------------------------------------------
// wcm_cell: one pattern position of the match chain
// Holds the active bit of its position and passes closure and advance
// carries to the next position.
// ----------------------------------------------------------------------------
module wcm_cell #(
   parameter logic START_BIT = 1'b0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [wcm_pkg::CHAR_W-1:0]  pat_char,
   input  logic [wcm_pkg::CHAR_W-1:0]  sub_char,
   input  logic                        enable,
   input  logic                        keep,
   input  logic                        accept,
   input  logic                        subject_end,
   input  wcm_pkg::link_type           link_in,
   output wcm_pkg::link_type           link_out,
   output logic                        act,
   output logic                        c0,
   output logic                        c1
);
   import wcm_pkg::*;

   logic act_ff, act_in;
   logic star, hit, adv_here;

   assign star = (pat_char == STAR_CHAR);
   assign hit  = (pat_char == sub_char);

   // closed set before the character, then advance, then close again
   assign c0       = (act_ff & keep) | link_in.close0;
   assign adv_here = link_in.adv | (enable & c0 & star);
   assign c1       = adv_here | link_in.close1;

   assign link_out.close0 = enable & star & c0;
   assign link_out.adv    = enable & c0 & (star | hit);
   assign link_out.close1 = enable & star & c1;

   assign act = act_ff;

   always_comb begin
      act_in = act_ff;
      if (accept) begin
         act_in = subject_end ? START_BIT : c1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= START_BIT;
      end else begin
         act_ff <= act_in;
      end
   end

endmodule

/* tb/sv/topic_match_checker.sv */
// ----------------------------------------------------------------------------
// topic_match_checker: result predictor and scoreboard for the match unit
// Follows the pattern registers and the accepted characters, computes the
// match flag of every subject end and compares it with the results taken.
// ----------------------------------------------------------------------------
module topic_match_checker (
   input  logic                            clock,
   input  logic                            reset,
   wcm_req_if                              req_mon,
   wcm_rsp_if                              rsp_mon,
   input  logic                            csr_wr_en,
   input  logic [wcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wcm_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                              mismatch_total,
   output int                              results_pending
);
   import wcm_pkg::*;

   localparam int MAX_POS      = MAX_PATTERN_CHARS_DEFAULT;
   localparam int REPORT_LIMIT = 10;
   localparam logic [MAX_POS:0] START_POS = (MAX_POS + 1)'(1);

   logic [PATTERN_W-1:0] pattern_bytes;
   logic [LEN_W-1:0]     pattern_len_reg;
   logic [MAX_POS:0]     live_positions;
   logic                 expected_match [$];
   int                   results_taken;

   function automatic logic [CHAR_W-1:0] pattern_byte(int pos);
      return pattern_bytes[CHAR_W*pos +: CHAR_W];
   endfunction

   function automatic int used_len();
      return (pattern_len_reg > MAX_POS) ? MAX_POS : int'(pattern_len_reg);
   endfunction

   function automatic logic [MAX_POS:0] span_mask(int len);
      logic [MAX_POS:0] m;
      m = '0;
      for (int i = 0; i <= len; i++) m[i] = 1'b1;
      return m;
   endfunction

   // an active star also opens the position after it, chained left to right
   function automatic logic [MAX_POS:0] close_star_runs(logic [MAX_POS:0] v, int len);
      for (int i = 0; i < len; i++) begin
         if (v[i] && pattern_byte(i) == STAR_CHAR) v[i+1] = 1'b1;
      end
      return v & span_mask(len);
   endfunction

   function automatic logic [MAX_POS:0] consume_char(logic [MAX_POS:0] v,
                                                     logic [CHAR_W-1:0] ch, int len);
      logic [MAX_POS:0] nxt;
      nxt = '0;
      for (int i = 0; i < len; i++) begin
         if (v[i]) begin
            if (pattern_byte(i) == STAR_CHAR) begin
               nxt[i]   = 1'b1;
               nxt[i+1] = 1'b1;
            end else if (pattern_byte(i) == ch) begin
               nxt[i+1] = 1'b1;
            end
         end
      end
      return nxt & span_mask(len);
   endfunction

   always @(posedge clock) begin : monitor
      logic [MAX_POS:0] reach;
      logic             want;
      int               len;
      if (reset) begin
         pattern_bytes   = '0;
         pattern_len_reg = '0;
         live_positions  = START_POS;
         expected_match.delete();
         mismatch_total  = 0;
         results_taken   = 0;
      end else begin
         // result side first: a result taken here belongs to an older subject
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_taken++;
            if (expected_match.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= REPORT_LIMIT)
                  $display("result %0d: is_match=%0b with no subject end outstanding",
                           results_taken, rsp_mon.is_match);
            end else begin
               want = expected_match.pop_front();
               if (rsp_mon.is_match !== want) begin
                  mismatch_total++;
                  if (mismatch_total <= REPORT_LIMIT)
                     $display("result %0d: is_match expected %0b, got %0b",
                              results_taken, want, rsp_mon.is_match);
               end
            end
         end

         if (csr_wr_en) begin
            case (csr_index)
               CSR_PATTERN_LOW:  pattern_bytes[CSR_DATA_W-1:0] = csr_wr_data;
               CSR_PATTERN_HIGH: pattern_bytes[PATTERN_W-1:CSR_DATA_W] = csr_wr_data;
               CSR_PATTERN_LEN:  pattern_len_reg = csr_wr_data[LEN_W-1:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            len   = used_len();
            reach = close_star_runs(live_positions & span_mask(len), len);
            if (req_mon.empty_subject) begin
               expected_match.push_back(reach[len]);
               live_positions = START_POS;
            end else begin
               reach = close_star_runs(consume_char(reach, req_mon.subject_char, len), len);
               if (req_mon.last_char) begin
                  expected_match.push_back(reach[len]);
                  live_positions = START_POS;
               end else begin
                  live_positions = reach;
               end
            end
         end
      end
      results_pending = expected_match.size();
   end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: top level for the wildcard topic match unit
// Writes a series of star patterns, streams directed and random subjects
// with random gaps and stalls, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
   import wcm_pkg::*;

   localparam int ITEM_TARGET     = 500;
   localparam int MIN_PHASES      = 10;
   localparam int SUBJECTS_PER_PH = 6;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_CYCLES    = 4;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int IDLE_PERCENT    = 20;

   localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   wcm_req_if req_chan ();
   wcm_rsp_if rsp_chan ();

   int mismatch_total;
   int results_pending;
   int cycle_count = 0;
   int items_sent  = 0;
   bit steady_flow  = 1'b0;   // both sides run without gaps
   bit hold_off_req = 1'b0;   // asks the result side for a long stall

   // copy of the pattern, only used to build subjects that can match
   logic [CHAR_W-1:0] pat_char [MAX_PATTERN_CHARS_DEFAULT];
   int                pat_len = 0;

   wildcard_topic_match_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   topic_match_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatch_total  (mismatch_total),
      .results_pending (results_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[wildcard_topic_match_unit] ERROR");
         $finish;
      end
   end

   // result side ready: random stalls, a quiet stretch, and one long hold-off
   initial begin : result_ready
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_chan.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // all three pattern registers in one burst; enable drops once at the end
   task automatic write_pattern(input logic [PATTERN_W-1:0] chars,
                                input logic [CSR_DATA_W-1:0] len_word);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PATTERN_LOW;
      csr_wr_data <= chars[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index   <= CSR_PATTERN_HIGH;
      csr_wr_data <= chars[PATTERN_W-1:CSR_DATA_W];
      @(negedge clock);
      csr_index   <= CSR_PATTERN_LEN;
      csr_wr_data <= len_word;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      for (int i = 0; i < MAX_PATTERN_CHARS_DEFAULT; i++)
         pat_char[i] = chars[CHAR_W*i +: CHAR_W];
      pat_len = (len_word[LEN_W-1:0] > MAX_PATTERN_CHARS_DEFAULT) ?
                MAX_PATTERN_CHARS_DEFAULT : int'(len_word[LEN_W-1:0]);
   endtask

   // sender goes quiet until every expected result is back
   // the extra cycles cover a character still in flight with no result
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one transfer on the character channel, with random gaps ahead of it
   task automatic push_item(input logic [CHAR_W-1:0] ch, input logic lst,
                            input logic emp);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid        <= 1'b0;
         req_chan.subject_char <= CHAR_W'($urandom);
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.subject_char  <= ch;
      req_chan.last_char     <= lst;
      req_chan.empty_subject <= emp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   function automatic logic [CHAR_W-1:0] random_pattern_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return STAR_CHAR;
      if (pick < 90) return CHAR_A + CHAR_W'($urandom_range(0, 2));
      if (pick < 95) return '0;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // well-formed subjects follow the pattern with short runs at the stars and
   // the odd wrong character; noise is a few arbitrary bytes
   task automatic send_subject(input bit well_formed);
      logic [CHAR_W-1:0] chars [$];
      bit                end_by_empty;
      if (well_formed) begin
         for (int i = 0; i < pat_len; i++) begin
            if (pat_char[i] == STAR_CHAR) begin
               repeat ($urandom_range(0, 3))
                  chars.push_back(CHAR_A + CHAR_W'($urandom_range(0, 2)));
            end else if ($urandom_range(0, 99) < 8) begin
               chars.push_back(CHAR_A + CHAR_W'($urandom_range(0, 2)));
            end else begin
               chars.push_back(pat_char[i]);
            end
         end
      end else begin
         repeat ($urandom_range(0, 6)) chars.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      // sometimes the subject is closed by an empty item instead of the last flag
      end_by_empty = (chars.size() == 0) || ($urandom_range(0, 99) < 10);
      foreach (chars[i])
         push_item(chars[i], !end_by_empty && (i == chars.size() - 1), 1'b0);
      if (end_by_empty)
         push_item(CHAR_W'($urandom), 1'($urandom), 1'b1);
   endtask

   initial begin : stimulus
      logic [PATTERN_W-1:0]  chars;
      logic [CSR_DATA_W-1:0] len_word;
      int                    phase;

      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_index              <= CSR_PATTERN_LOW;
      csr_wr_data            <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.subject_char  <= '0;
      req_chan.last_char     <= 1'b0;
      req_chan.empty_subject <= 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pattern after reset: only the empty subject matches
      push_item('0, 1'b0, 1'b1);
      push_item(CHAR_A, 1'b1, 1'b0);
      settle();

      // "a*": trailing star takes an empty run
      chars = '0;
      chars[7:0]  = CHAR_A;
      chars[15:8] = STAR_CHAR;
      write_pattern(chars, 64'd2);
      push_item(CHAR_A, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b1);
      push_item(CHAR_A, 1'b0, 1'b0);
      push_item(CHAR_A + 8'd1, 1'b1, 1'b0);
      // empty item closes a subject already under way
      push_item(CHAR_A, 1'b0, 1'b0);
      push_item(8'h55, 1'b1, 1'b1);
      settle();

      // zero byte in the pattern is a literal; star char in the subject too
      chars = {PATTERN_W{1'b1}};
      chars[7:0]   = 8'h00;
      chars[15:8]  = STAR_CHAR;
      chars[23:16] = 8'hFF;
      write_pattern(chars, 64'd3);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(STAR_CHAR, 1'b0, 1'b0);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'h01, 1'b0, 1'b0);
      push_item(8'hFF, 1'b1, 1'b0);
      settle();

      // length field above the maximum, upper data bits all set
      write_pattern({(PATTERN_W/CHAR_W){STAR_CHAR}}, {CSR_DATA_W{1'b1}});
      push_item(8'h71, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      settle();

      // new pattern written while a subject is half done
      chars = '0;
      chars[7:0]  = CHAR_A;
      chars[15:8] = CHAR_A + 8'd1;
      write_pattern(chars, 64'd2);
      push_item(CHAR_A, 1'b0, 1'b0);
      settle();
      chars[15:8] = CHAR_A + 8'd2;
      write_pattern(chars, 64'd2);
      push_item(CHAR_A + 8'd2, 1'b1, 1'b0);
      settle();

      // random phases, each on a fresh pattern; random upper length bits
      phase = 0;
      while (items_sent < ITEM_TARGET || phase < MIN_PHASES) begin
         for (int i = 0; i < MAX_PATTERN_CHARS_DEFAULT; i++)
            chars[CHAR_W*i +: CHAR_W] = random_pattern_byte();
         len_word = {$urandom, $urandom};
         case (phase)
            0: len_word[LEN_W-1:0] = 5'd16;
            1: len_word[LEN_W-1:0] = 5'd31;
            2: len_word[LEN_W-1:0] = 5'd0;
            default: len_word[LEN_W-1:0] = ($urandom_range(0, 9) == 0) ?
                        LEN_W'($urandom_range(17, 31)) : LEN_W'($urandom_range(1, 16));
         endcase
         write_pattern(chars, len_word);
         steady_flow = (phase == 3);
         // long receiver stall while characters keep coming: the block fills up
         if (phase == 4) hold_off_req = 1'b1;
         repeat (SUBJECTS_PER_PH) send_subject($urandom_range(0, 99) < 80);
         settle();
         phase++;
      end
      steady_flow = 1'b0;

      if (mismatch_total == 0)
         $display("[wildcard_topic_match_unit] OK");
      else
         $display("[wildcard_topic_match_unit] ERROR");
      $finish;
   end

endmodule
